@@ hdl/rbp_pkg.sv @@
// Shared types, constants and the arctangent table of the radar blip projection unit.
`default_nettype none

package rbp_pkg;

    typedef struct packed {
        logic signed [23:0] target_x;
        logic signed [23:0] target_z;
        logic signed [23:0] viewer_x;
        logic signed [23:0] viewer_z;
        logic signed [15:0] heading_cos;
        logic signed [15:0] heading_sin;
    } rbp_in_t;

    typedef struct packed {
        logic        [23:0] distance;
        logic        [14:0] left_percent;
        logic        [14:0] top_percent;
        logic signed [15:0] arrow_degrees;
    } rbp_out_t;

    localparam logic [22:0] RANGE_RESET  = 23'd12800;
    localparam int          PCT_CENTRE   = 12800;
    localparam int          PCT_MAX      = 25600;
    localparam int          DEG_OFFSET   = 5760;
    localparam int          DEG_LOW      = -5760;
    localparam int          DEG_HIGH     = 17280;
    localparam int          QUARTER_TURN = 1474560;
    localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

    // Square root steps for a 50-bit radicand, and quotient bits of the percent divide.
    localparam int SQRT_STEPS = 25;
    localparam int QUO_BITS   = 14;
    localparam int ACC_W      = 24;
    localparam int VEC_W      = 44;

    // atan(2^-i) in degrees times 16384.
    function automatic logic signed [ACC_W-1:0] atan_step(input int unsigned idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = 24'sd737280;
            1:       v = 24'sd435242;
            2:       v = 24'sd229970;
            3:       v = 24'sd116736;
            4:       v = 24'sd58595;
            5:       v = 24'sd29326;
            6:       v = 24'sd14667;
            7:       v = 24'sd7334;
            8:       v = 24'sd3667;
            9:       v = 24'sd1833;
            10:      v = 24'sd917;
            11:      v = 24'sd458;
            12:      v = 24'sd229;
            13:      v = 24'sd115;
            14:      v = 24'sd57;
            15:      v = 24'sd29;
            16:      v = 24'sd14;
            17:      v = 24'sd7;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/radar_blip_projection_unit.sv @@
// Radar blip projection: a fully pipelined unit that accepts one target every clock cycle.
// The length comes from a 25-stage digit-by-digit square root, the percent divides from a
// 15-stage restoring divider, and the angle from a CORDIC whose ANGLE_ITERATIONS stages
// (8 to 24) run beside the square root. When the result at the output is not taken, the
// whole pipeline holds, so s_ready follows m_ready in that case. radar_range is sampled
// while items are in flight and should only be written when idle.
`default_nettype none

module radar_blip_projection_unit #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [22:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  rbp_pkg::rbp_in_t       s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rbp_pkg::rbp_out_t      m_data
);
    import rbp_pkg::*;

    localparam int DIV_STAGES = QUO_BITS + 1;
    localparam int LAT        = 3 + SQRT_STEPS + 1 + DIV_STAGES + 1;

    logic             adv;
    logic [LAT-1:0]   vld_reg;
    logic [22:0]      range_reg;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
        end else if (cfg_we) begin
            range_reg <= cfg_wdata;
        end
    end

    // Offsets.
    logic signed [24:0] dx_reg, dz_reg;
    logic signed [15:0] cs_reg, sn_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= 25'(s_data.target_x) - 25'(s_data.viewer_x);
            dz_reg <= 25'(s_data.target_z) - 25'(s_data.viewer_z);
            cs_reg <= s_data.heading_cos;
            sn_reg <= s_data.heading_sin;
        end
    end

    // Products.
    logic        [48:0] dxx_reg, dzz_reg;
    logic signed [40:0] dxc_reg, dzs_reg, dxs_reg, dzc_reg;
    logic        [45:0] rr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dxx_reg <= 49'(dx_reg * dx_reg);
            dzz_reg <= 49'(dz_reg * dz_reg);
            dxc_reg <= 41'(dx_reg * cs_reg);
            dzs_reg <= 41'(dz_reg * sn_reg);
            dxs_reg <= 41'(dx_reg * sn_reg);
            dzc_reg <= 41'(dz_reg * cs_reg);
            rr_reg  <= 46'(range_reg * range_reg);
        end
    end

    // Sums and the rim test.
    logic        [49:0] sq_next, sq_reg;
    logic signed [41:0] rx_reg, ry_reg;
    logic               clamp_reg;

    assign sq_next = 50'(dxx_reg) + 50'(dzz_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg    <= sq_next;
            rx_reg    <= 42'(dxc_reg) - 42'(dzs_reg);
            ry_reg    <= 42'(dxs_reg) + 42'(dzc_reg);
            clamp_reg <= sq_next > 50'(rr_reg);
        end
    end

    // Square root stages, with the CORDIC and the rotated offsets alongside.
    logic        [49:0]       sv_reg  [SQRT_STEPS];
    logic        [49:0]       res_reg [SQRT_STEPS];
    logic signed [41:0]       rxp_reg [SQRT_STEPS];
    logic signed [41:0]       ryp_reg [SQRT_STEPS];
    logic                     clp_reg [SQRT_STEPS];
    logic signed [VEC_W-1:0]  cx_reg  [SQRT_STEPS];
    logic signed [VEC_W-1:0]  cy_reg  [SQRT_STEPS];
    logic signed [ACC_W-1:0]  ca_reg  [SQRT_STEPS];
    logic                     cz_reg  [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
        localparam logic [49:0] BIT = 50'(1) << (2 * (SQRT_STEPS - 1 - j));

        logic        [49:0] v_in, res_in, v_next, res_next;
        logic        [50:0] trial;
        logic signed [41:0] rx_in, ry_in;
        logic               cl_in;

        if (j == 0) begin : g_src
            assign v_in   = sq_reg;
            assign res_in = '0;
            assign rx_in  = rx_reg;
            assign ry_in  = ry_reg;
            assign cl_in  = clamp_reg;
        end else begin : g_src
            assign v_in   = sv_reg[j-1];
            assign res_in = res_reg[j-1];
            assign rx_in  = rxp_reg[j-1];
            assign ry_in  = ryp_reg[j-1];
            assign cl_in  = clp_reg[j-1];
        end

        assign trial = {1'b0, res_in} + {1'b0, BIT};

        always_comb begin
            if ({1'b0, v_in} >= trial) begin
                v_next   = v_in - trial[49:0];
                res_next = (res_in >> 1) + BIT;
            end else begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sv_reg[j]  <= v_next;
                res_reg[j] <= res_next;
                rxp_reg[j] <= rx_in;
                ryp_reg[j] <= ry_in;
                clp_reg[j] <= cl_in;
            end
        end

        logic signed [VEC_W-1:0] cx_next, cy_next;
        logic signed [ACC_W-1:0] ca_next;
        logic                    cz_next;

        if (j == 0) begin : g_cordic
            logic signed [VEC_W-1:0] x0, y0;
            assign x0 = VEC_W'(rx_reg);
            assign y0 = VEC_W'(ry_reg);
            // Quarter-turn pre-rotation brings the vector into the right half plane.
            always_comb begin
                cz_next = (rx_reg == '0) && (ry_reg == '0);
                if (x0 < 0 && y0 >= 0) begin
                    cx_next = y0;
                    cy_next = -x0;
                    ca_next = ACC_W'(QUARTER_TURN);
                end else if (x0 < 0) begin
                    cx_next = -y0;
                    cy_next = x0;
                    ca_next = -ACC_W'(QUARTER_TURN);
                end else begin
                    cx_next = x0;
                    cy_next = y0;
                    ca_next = '0;
                end
            end
        end else if (j <= ANGLE_ITERATIONS) begin : g_cordic
            localparam int                      I    = j - 1;
            localparam logic signed [ACC_W-1:0] ATAN = atan_step(I);
            logic signed [VEC_W-1:0] xs, ys;
            assign xs = cx_reg[j-1] >>> I;
            assign ys = cy_reg[j-1] >>> I;
            always_comb begin
                cz_next = cz_reg[j-1];
                if (cy_reg[j-1] >= 0) begin
                    cx_next = cx_reg[j-1] + ys;
                    cy_next = cy_reg[j-1] - xs;
                    ca_next = ca_reg[j-1] + ATAN;
                end else begin
                    cx_next = cx_reg[j-1] - ys;
                    cy_next = cy_reg[j-1] + xs;
                    ca_next = ca_reg[j-1] - ATAN;
                end
            end
        end else begin : g_cordic
            assign cx_next = cx_reg[j-1];
            assign cy_next = cy_reg[j-1];
            assign ca_next = ca_reg[j-1];
            assign cz_next = cz_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cx_reg[j] <= cx_next;
                cy_reg[j] <= cy_next;
                ca_reg[j] <= ca_next;
                cz_reg[j] <= cz_next;
            end
        end
    end

    // Divisor select and numerators.
    localparam int LS = SQRT_STEPS - 1;

    logic        [24:0]      d_next;
    logic        [41:0]      mag_next [2];
    logic        [47:0]      en_reg   [2];
    logic                    es_reg   [2];
    logic        [30:0]      em_reg;
    logic                    edz_reg;
    logic        [23:0]      edist_reg;
    logic signed [ACC_W-1:0] eacc_reg;
    logic                    ezero_reg;

    assign d_next      = clp_reg[LS] ? res_reg[LS][24:0] : {2'b00, range_reg};
    assign mag_next[0] = rxp_reg[LS][41] ? 42'(-rxp_reg[LS]) : 42'(rxp_reg[LS]);
    assign mag_next[1] = ryp_reg[LS][41] ? 42'(-ryp_reg[LS]) : 42'(ryp_reg[LS]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                en_reg[l] <= (48'(mag_next[l]) << 5) + (48'(mag_next[l]) << 4)
                           + (48'(mag_next[l]) << 1);
            end
            es_reg[0] <= rxp_reg[LS][41];
            es_reg[1] <= ryp_reg[LS][41];
            em_reg    <= {d_next, 6'b0};
            edz_reg   <= d_next == '0;
            edist_reg <= (res_reg[LS][49:24] != '0) ? DIST_MAX : res_reg[LS][23:0];
            eacc_reg  <= ca_reg[LS];
            ezero_reg <= cz_reg[LS];
        end
    end

    // Restoring divider: a saturation test, then one quotient bit per stage.
    logic        [47:0]         qr_reg   [DIV_STAGES][2];
    logic        [QUO_BITS-1:0] qq_reg   [DIV_STAGES][2];
    logic                       qsat_reg [DIV_STAGES][2];
    logic                       qs_reg   [DIV_STAGES][2];
    logic        [30:0]         qm_reg   [DIV_STAGES];
    logic                       qdz_reg  [DIV_STAGES];
    logic        [23:0]         qdist_reg[DIV_STAGES];
    logic signed [ACC_W-1:0]    qacc_reg [DIV_STAGES];
    logic                       qzero_reg[DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [47:0]         r_next   [2];
        logic [QUO_BITS-1:0] q_next   [2];
        logic                sat_next [2];

        if (k == 0) begin : g_step
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    r_next[l]   = en_reg[l];
                    q_next[l]   = '0;
                    sat_next[l] = en_reg[l] >= (48'(em_reg) << QUO_BITS);
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int l = 0; l < 2; l++) begin
                        qs_reg[k][l] <= es_reg[l];
                    end
                    qm_reg[k]    <= em_reg;
                    qdz_reg[k]   <= edz_reg;
                    qdist_reg[k] <= edist_reg;
                    qacc_reg[k]  <= eacc_reg;
                    qzero_reg[k] <= ezero_reg;
                end
            end
        end else begin : g_step
            localparam int B = QUO_BITS - k;
            logic [47:0] dv;
            assign dv = 48'(qm_reg[k-1]) << B;
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    sat_next[l] = qsat_reg[k-1][l];
                    q_next[l]   = qq_reg[k-1][l];
                    if (qr_reg[k-1][l] >= dv) begin
                        r_next[l]    = qr_reg[k-1][l] - dv;
                        q_next[l][B] = 1'b1;
                    end else begin
                        r_next[l] = qr_reg[k-1][l];
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int l = 0; l < 2; l++) begin
                        qs_reg[k][l] <= qs_reg[k-1][l];
                    end
                    qm_reg[k]    <= qm_reg[k-1];
                    qdz_reg[k]   <= qdz_reg[k-1];
                    qdist_reg[k] <= qdist_reg[k-1];
                    qacc_reg[k]  <= qacc_reg[k-1];
                    qzero_reg[k] <= qzero_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    qr_reg[k][l]   <= r_next[l];
                    qq_reg[k][l]   <= q_next[l];
                    qsat_reg[k][l] <= sat_next[l];
                end
            end
        end
    end

    // Output register: percents around the centre and the rounded arrow angle.
    localparam int LD = DIV_STAGES - 1;

    rbp_out_t                out_next, out_reg;
    logic     [QUO_BITS-1:0] qv   [2];
    logic signed [16:0]      pv   [2];
    logic     [14:0]         pct  [2];
    logic signed [ACC_W-1:0] rnd;
    logic signed [16:0]      deg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // A zero divisor only happens for a target at the viewer; it stays centered.
            if (qdz_reg[LD]) begin
                qv[l] = '0;
            end else if (qsat_reg[LD][l]) begin
                qv[l] = '1;
            end else begin
                qv[l] = qq_reg[LD][l];
            end
            if (qs_reg[LD][l]) begin
                pv[l] = 17'(PCT_CENTRE) - $signed({3'b000, qv[l]});
            end else begin
                pv[l] = 17'(PCT_CENTRE) + $signed({3'b000, qv[l]});
            end
            if (pv[l] < 0) begin
                pct[l] = '0;
            end else if (pv[l] > 17'(PCT_MAX)) begin
                pct[l] = 15'(PCT_MAX);
            end else begin
                pct[l] = 15'(pv[l]);
            end
        end
        rnd = qacc_reg[LD] + ACC_W'(128);
        deg = 17'(rnd >>> 8) + 17'(DEG_OFFSET);
        out_next.distance     = qdist_reg[LD];
        out_next.left_percent = pct[0];
        out_next.top_percent  = pct[1];
        if (qzero_reg[LD]) begin
            out_next.arrow_degrees = 16'(DEG_OFFSET);
        end else if (deg < 17'(DEG_LOW)) begin
            out_next.arrow_degrees = 16'(DEG_LOW);
        end else if (deg > 17'(DEG_HIGH)) begin
            out_next.arrow_degrees = 16'(DEG_HIGH);
        end else begin
            out_next.arrow_degrees = 16'(deg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

@@ tb/sv/radar_blip_projection_unit_tb.sv @@
// Self-checking testbench for the radar blip projection unit with a built-in predictor.
`default_nettype none

module radar_blip_projection_unit_tb;
    import rbp_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 45;
    localparam int IN_W = $bits(rbp_in_t);
    localparam longint ATAN_DEG [24] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [22:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    rbp_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rbp_out_t    m_data;

    rbp_out_t    expected_blips[$];
    logic [22:0] radar_range = RANGE_RESET;
    int          errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_off = 1'b0;

    radar_blip_projection_unit #(.ANGLE_ITERATIONS(STEPS)) DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

    always #5 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint pct_of(longint r, longint d);
        longint p = PCT_CENTRE;
        if (d > 0) p = p + (50 * r) / (64 * d);
        if (p < 0) p = 0;
        if (p > PCT_MAX) p = PCT_MAX;
        return p;
    endfunction

    function automatic longint bearing_of(longint x, longint y);
        longint acc = 0;
        longint t, xs, ys, deg;
        if (x == 0 && y == 0) return DEG_OFFSET;
        // Fold the left half plane over by a quarter turn so the CORDIC converges.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = QUARTER_TURN;
            end else begin
                t = x; x = -y; y = t; acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc = acc + ATAN_DEG[i];
            end else begin
                x = x - ys; y = y + xs; acc = acc - ATAN_DEG[i];
            end
        end
        deg = ((acc + 128) >>> 8) + DEG_OFFSET;
        if (deg < DEG_LOW) deg = DEG_LOW;
        if (deg > DEG_HIGH) deg = DEG_HIGH;
        return deg;
    endfunction

    function automatic rbp_out_t project_blip(rbp_in_t b, logic [22:0] rng);
        longint dx, dz, c, s, rx, ry, d;
        longint unsigned sq, root, r;
        rbp_out_t o;
        dx = longint'(b.target_x) - longint'(b.viewer_x);
        dz = longint'(b.target_z) - longint'(b.viewer_z);
        c = longint'(b.heading_cos);
        s = longint'(b.heading_sin);
        sq = dx * dx + dz * dz;
        root = int_sqrt(sq);
        r = rng;
        rx = dx * c - dz * s;
        ry = dx * s + dz * c;
        d = (sq > r * r) ? longint'(root) : longint'(r);
        o.distance = (root > 64'hFFFFFF) ? DIST_MAX : root[23:0];
        o.left_percent = 15'(pct_of(rx, d));
        o.top_percent = 15'(pct_of(ry, d));
        o.arrow_degrees = 16'(bearing_of(rx, ry));
        return o;
    endfunction

    // Result checker: each transfer on the result side is matched against the oldest prediction.
    always @(posedge aclk) begin
        rbp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blips.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                want = expected_blips.pop_front();
                if (m_data.distance !== want.distance) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, m_data.distance);
                    errors++;
                end
                if (m_data.left_percent !== want.left_percent) begin
                    $display("%0t: left_percent expected %0d actual %0d",
                             $time, want.left_percent, m_data.left_percent);
                    errors++;
                end
                if (m_data.top_percent !== want.top_percent) begin
                    $display("%0t: top_percent expected %0d actual %0d",
                             $time, want.top_percent, m_data.top_percent);
                    errors++;
                end
                if (m_data.arrow_degrees !== want.arrow_degrees) begin
                    $display("%0t: arrow_degrees expected %0d actual %0d",
                             $time, want.arrow_degrees, m_data.arrow_degrees);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic send_blip(rbp_in_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        expected_blips.push_back(project_blip(b, radar_range));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (expected_blips.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_range(logic [22:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        radar_range = v;
    endtask

    function automatic rbp_in_t make_blip(logic signed [23:0] tx, logic signed [23:0] tz,
                                          logic signed [23:0] vx, logic signed [23:0] vz,
                                          logic signed [15:0] hc, logic signed [15:0] hs);
        rbp_in_t b;
        b.target_x = tx; b.target_z = tz; b.viewer_x = vx; b.viewer_z = vz;
        b.heading_cos = hc; b.heading_sin = hs;
        return b;
    endfunction

    // Mostly viewers with a unit heading and targets around the radar rim; some raw noise.
    function automatic rbp_in_t random_blip();
        rbp_in_t b;
        real a;
        int spread;
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(9) < 8) begin
            a = $urandom_range(35999) * 3.14159265 / 18000.0;
            b.heading_cos = 16'(int'($cos(a) * 16384.0));
            b.heading_sin = 16'(int'($sin(a) * 16384.0));
            spread = 2 * int'(radar_range) + 2;
            if (spread > 4000000) spread = 4000000;
            if ($urandom_range(3) == 0) spread = 16;
            b.viewer_x = 24'($signed($urandom_range(8000000)) - 4000000);
            b.viewer_z = 24'($signed($urandom_range(8000000)) - 4000000);
            b.target_x = b.viewer_x + 24'($signed($urandom_range(2 * spread)) - spread);
            b.target_z = b.viewer_z + 24'($signed($urandom_range(2 * spread)) - spread);
        end
        return b;
    endfunction

    task automatic test_directed;
        send_blip(make_blip(0, 0, 0, 0, 16384, 0));
        send_blip(make_blip(24'sd1000, 24'sd1000, 24'sd1000, 24'sd1000, 0, 16384));
        send_blip(make_blip(24'sd3200, 0, 0, 0, 0, 0));
        send_blip(make_blip(24'sd3200, 24'sd100, 0, 0, 16384, 0));
        send_blip(make_blip(24'sd12800, 0, 0, 0, 16384, 0));
        send_blip(make_blip(24'sd12801, 0, 0, 0, 16384, 0));
        send_blip(make_blip(0, 24'sd12800, 0, 0, 16384, 0));
        send_blip(make_blip(-24'sd12800, 0, 0, 0, 16384, 0));
        send_blip(make_blip(0, -24'sd900000, 0, 0, -16384, 0));
        send_blip(make_blip(-24'sd500, -24'sd700, 0, 0, 0, -16384));
        send_blip(make_blip(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16384, 0));
        send_blip(make_blip(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h7FFF));
        send_blip(make_blip(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000));
        send_blip(make_blip(24'sd5000, 24'sd300, 0, 0, 16'h7FFF, 16'h7FFF));
        send_blip(make_blip(-24'sd5000, 24'sd1, 0, 0, 16384, 0));
        send_blip(make_blip(-24'sd5000, -24'sd1, 0, 0, 16384, 0));
        send_blip(make_blip(24'sd1, 0, 0, 0, 11585, 11585));
    endtask

    task automatic test_range_settings;
        logic [22:0] ranges [5] = '{23'd0, 23'd1, 23'h7FFFFF, 23'd256, RANGE_RESET};
        foreach (ranges[k]) begin
            set_range(ranges[k]);
            send_blip(make_blip(0, 0, 0, 0, 16384, 0));
            send_blip(make_blip(24'sd1, 0, 0, 0, 16384, 0));
            send_blip(make_blip(24'sd300, -24'sd200, 0, 0, 11585, -11585));
            for (int i = 0; i < 10; i++) send_blip(random_blip());
        end
    endtask

    task automatic random_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) send_blip(random_blip());
    endtask

    task automatic test_random;
        random_phase(0, 0, 200);
        set_range(23'($urandom_range(1, 8388607)));
        random_phase(50, 0, 180);
        set_range(23'($urandom_range(1, 20000)));
        random_phase(0, 50, 180);
        set_range(RANGE_RESET);
        random_phase(32, 32, 180);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input side.
    task automatic test_backpressure;
        fork
            begin
                @(posedge aclk);
                hold_off <= 1'b1;
                repeat (150) @(posedge aclk);
                hold_off <= 1'b0;
            end
            random_phase(0, 0, 120);
        join
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_range_settings();
        test_random();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

@@ radar_blip_projection_unit.f @@
hdl/rbp_pkg.sv
hdl/radar_blip_projection_unit.sv
tb/sv/radar_blip_projection_unit_tb.sv
